FILE: sv/e2c_pkg.sv
// shared types, constants and calendar helpers for the epoch to calendar date block
`timescale 1ns / 1ps

package e2c_pkg;

   // seconds per day is 2^7 * 675, so the day split is a shift plus a divide by 675
   localparam int unsigned DAY_SHIFT = 7;
   localparam logic [15:0] DIV_DAY   = 16'd675;
   localparam logic [15:0] DIV_HOUR  = 16'd3600;
   localparam logic [15:0] DIV_MIN   = 16'd60;
   localparam logic [15:0] DIV_WEEK  = 16'd7;

   localparam logic [15:0] YEAR_DAYS     = 16'd365;
   localparam logic [7:0]  BASE_YEAR     = 8'd70;
   localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;

   // century years in reach of an 8-bit year count (1900 and 2100 are not leap)
   localparam logic [7:0] YEAR_1900 = 8'd0;
   localparam logic [7:0] YEAR_2100 = 8'd200;

   localparam logic [3:0] MON_JAN = 4'd0;
   localparam logic [3:0] MON_FEB = 4'd1;
   localparam logic [3:0] MON_MAR = 4'd2;
   localparam logic [3:0] MON_APR = 4'd3;
   localparam logic [3:0] MON_MAY = 4'd4;
   localparam logic [3:0] MON_JUN = 4'd5;
   localparam logic [3:0] MON_JUL = 4'd6;
   localparam logic [3:0] MON_AUG = 4'd7;
   localparam logic [3:0] MON_SEP = 4'd8;
   localparam logic [3:0] MON_OCT = 4'd9;
   localparam logic [3:0] MON_NOV = 4'd10;
   localparam logic [3:0] MON_DEC = 4'd11;

   // operands and result of the shared compare-subtract unit
   typedef struct packed {
      logic [15:0] a;
      logic [15:0] b;
   } sub_req_type;

   typedef struct packed {
      logic [15:0] diff;
      logic        ge;
   } sub_rsp_type;

   // one converted result item
   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [4:0] month_day;
      logic [3:0] month;
      logic [7:0] year_since_1900;
      logic [8:0] year_day;
      logic       range_error;
   } date_type;

   // gregorian leap test on the full year; 1900 is divisible by 4 so the low
   // bits of the 1900-based count decide the multiple-of-four part
   function automatic logic is_leap(input logic [7:0] ys);
      is_leap = (ys[1:0] == 2'b00) && (ys != YEAR_1900) && (ys != YEAR_2100);
   endfunction

   // month length with leap february
   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      case (mon)
         MON_JAN, MON_MAR, MON_MAY, MON_JUL,
         MON_AUG, MON_OCT, MON_DEC: month_len = 5'd31;
         MON_APR, MON_JUN, MON_SEP, MON_NOV: month_len = 5'd30;
         MON_FEB: month_len = leap ? 5'd29 : 5'd28;
         default: month_len = 5'd31;
      endcase
   endfunction

endpackage

FILE: sv/e2c_sub_unit.sv
// shared 16-bit compare-subtract unit used by every phase of the conversion
`timescale 1ns / 1ps

module e2c_sub_unit (
   input  e2c_pkg::sub_req_type req,
   output e2c_pkg::sub_rsp_type rsp
);
   import e2c_pkg::*;

   logic [16:0] wide_diff;

   // borrow out of the top bit means a < b
   assign wide_diff = {1'b0, req.a} - {1'b0, req.b};
   assign rsp.diff  = wide_diff[15:0];
   assign rsp.ge    = ~wide_diff[16];

endmodule

FILE: sv/e2c_convert.sv
// sequencer that runs the restoring divides and the year and month loops on one subtractor
`timescale 1ns / 1ps

module e2c_convert (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [31:0]       in_time,
   input  logic              in_error,
   output logic              out_valid,
   input  logic              out_ready,
   output e2c_pkg::date_type out_date
);
   import e2c_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DAY  = 3'd1;
   localparam logic [2:0] ST_HOUR = 3'd2;
   localparam logic [2:0] ST_MIN  = 3'd3;
   localparam logic [2:0] ST_WDAY = 3'd4;
   localparam logic [2:0] ST_YEAR = 3'd5;
   localparam logic [2:0] ST_MON  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [11:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [6:0]  t7_ff, t7_in;
   logic [15:0] days_ff, days_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [2:0]  weekday_ff, weekday_in;
   logic [7:0]  year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [8:0]  yday_ff, yday_in;
   logic        err_ff, err_in;

   sub_req_type sub_req;
   sub_rsp_type sub_rsp;
   logic [11:0] div_rem;
   logic [15:0] div_quo;
   logic [15:0] wday_arg;
   logic        leap;

   e2c_sub_unit u_sub (
      .req (sub_req),
      .rsp (sub_rsp)
   );

   assign leap = is_leap(year_ff);

   // operand select: divide trial in the divide phases, day count in the loops
   always_comb begin
      sub_req.a = {3'b000, rem_ff, quo_ff[15]};
      sub_req.b = DIV_DAY;
      case (state_ff)
         ST_HOUR: sub_req.b = DIV_HOUR;
         ST_MIN:  sub_req.b = DIV_MIN;
         ST_WDAY: sub_req.b = DIV_WEEK;
         ST_YEAR: begin
            sub_req.a = days_ff;
            sub_req.b = YEAR_DAYS + {15'd0, leap};
         end
         ST_MON: begin
            sub_req.a = days_ff;
            sub_req.b = {11'd0, month_len(month_ff, leap)};
         end
         default: sub_req.b = DIV_DAY;
      endcase
   end

   // one restoring divide step
   assign div_rem  = sub_rsp.ge ? sub_rsp.diff[11:0] : sub_req.a[11:0];
   assign div_quo  = {quo_ff[14:0], sub_rsp.ge};
   assign wday_arg = days_ff + EPOCH_WEEKDAY;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      t7_in      = t7_ff;
      days_in    = days_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      weekday_in = weekday_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      yday_in    = yday_ff;
      err_in     = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               // time >> 7 divided by 675; top bits seed the remainder
               rem_in   = {3'b000, in_time[31:23]};
               quo_in   = in_time[22:DAY_SHIFT];
               t7_in    = in_time[DAY_SHIFT-1:0];
               err_in   = in_error;
               step_in  = 4'd15;
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            rem_in  = div_rem;
            quo_in  = div_quo;
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               // second of day is remainder * 128 + low bits; seed the hour divide
               days_in  = div_quo;
               rem_in   = {div_rem[9:0], t7_ff[6:5]};
               quo_in   = {t7_ff[4:0], 11'd0};
               step_in  = 4'd4;
               state_in = ST_HOUR;
            end
         end
         ST_HOUR: begin
            rem_in  = div_rem;
            quo_in  = div_quo;
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               hour_in  = div_quo[4:0];
               rem_in   = {6'd0, div_rem[11:6]};
               quo_in   = {div_rem[5:0], 10'd0};
               step_in  = 4'd5;
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            rem_in  = div_rem;
            quo_in  = div_quo;
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               minute_in = div_quo[5:0];
               second_in = div_rem[5:0];
               rem_in    = {10'd0, wday_arg[15:14]};
               quo_in    = {wday_arg[13:0], 2'b00};
               step_in   = 4'd13;
               state_in  = ST_WDAY;
            end
         end
         ST_WDAY: begin
            rem_in  = div_rem;
            quo_in  = div_quo;
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               weekday_in = div_rem[2:0];
               year_in    = BASE_YEAR;
               state_in   = ST_YEAR;
            end
         end
         ST_YEAR: begin
            // strip whole years
            if (sub_rsp.ge) begin
               days_in = sub_rsp.diff;
               year_in = year_ff + 8'd1;
            end else begin
               yday_in  = days_ff[8:0];
               month_in = MON_JAN;
               state_in = ST_MON;
            end
         end
         ST_MON: begin
            // strip whole months, december takes the rest
            if ((month_ff == LAST_MONTH) || !sub_rsp.ge) begin
               state_in = ST_DONE;
            end else begin
               days_in  = sub_rsp.diff;
               month_in = month_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      t7_ff      <= t7_in;
      days_ff    <= days_in;
      hour_ff    <= hour_in;
      minute_ff  <= minute_in;
      second_ff  <= second_in;
      weekday_ff <= weekday_in;
      year_ff    <= year_in;
      month_ff   <= month_in;
      yday_ff    <= yday_in;
      err_ff     <= err_in;
   end

   // result item
   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);

   assign out_date.second          = second_ff;
   assign out_date.minute          = minute_ff;
   assign out_date.hour            = hour_ff;
   assign out_date.weekday         = weekday_ff;
   assign out_date.month_day       = days_ff[4:0] + 5'd1;
   assign out_date.month           = month_ff;
   assign out_date.year_since_1900 = year_ff;
   assign out_date.year_day        = yday_ff;
   assign out_date.range_error     = err_ff;

endmodule

FILE: sv/epoch_to_calendar_date.sv
// top level: offset register, clamp of the adjusted time, and the conversion sequencer
// throughput: one item at a time; the next is taken the cycle after the result is taken
// the work runs on one shared 16-bit subtractor: 41 divide steps, then one step per year and one per month
// reset: synchronous, active high; clears the offset to zero and returns the sequencer to idle
// no item is accepted while reset is high
`timescale 1ns / 1ps

module epoch_to_calendar_date (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_epoch_seconds,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_second,
   output logic [5:0]         rsp_minute,
   output logic [4:0]         rsp_hour,
   output logic [2:0]         rsp_weekday,
   output logic [4:0]         rsp_month_day,
   output logic [3:0]         rsp_month,
   output logic [7:0]         rsp_year_since_1900,
   output logic [8:0]         rsp_year_day,
   output logic               rsp_range_error,
   input  logic               csr_wr_en,
   input  logic signed [17:0] csr_wr_data
);
   import e2c_pkg::*;

   logic signed [17:0] offset_ff;
   logic signed [17:0] offset_in;
   logic signed [33:0] adj_time;
   logic [31:0]        clamped_time;
   logic               clamp_error;
   logic               conv_ready;
   logic               conv_valid;
   date_type           date;

   // offset register
   assign offset_in = csr_wr_en ? csr_wr_data : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   // add offset and clamp to the unsigned 32-bit range
   assign adj_time = $signed({2'b00, req_epoch_seconds})
                   + $signed({{16{offset_ff[17]}}, offset_ff});

   always_comb begin
      clamped_time = adj_time[31:0];
      clamp_error  = 1'b0;
      if (adj_time[33]) begin
         clamped_time = '0;
         clamp_error  = 1'b1;
      end else if (adj_time[32]) begin
         clamped_time = '1;
         clamp_error  = 1'b1;
      end
   end

   e2c_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid && !reset),
      .in_ready  (conv_ready),
      .in_time   (clamped_time),
      .in_error  (clamp_error),
      .out_valid (conv_valid),
      .out_ready (rsp_ready),
      .out_date  (date)
   );

   // handshake and result fields
   assign req_ready           = conv_ready && !reset;
   assign rsp_valid           = conv_valid;
   assign rsp_second          = date.second;
   assign rsp_minute          = date.minute;
   assign rsp_hour            = date.hour;
   assign rsp_weekday         = date.weekday;
   assign rsp_month_day       = date.month_day;
   assign rsp_month           = date.month;
   assign rsp_year_since_1900 = date.year_since_1900;
   assign rsp_year_day        = date.year_day;
   assign rsp_range_error     = date.range_error;

endmodule

FILE: sv/e2c_checker.sv
// port-level checks for the epoch to calendar date block, bound to the top level
`timescale 1ns / 1ps

module e2c_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_second,
   input logic [5:0] rsp_minute,
   input logic [4:0] rsp_hour,
   input logic [2:0] rsp_weekday,
   input logic [4:0] rsp_month_day,
   input logic [3:0] rsp_month
);
   import e2c_pkg::*;

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an accepted item starts a multi-cycle conversion
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!rsp_valid && !req_ready))
      else $error("block not busy after item accepted");

   // one item at a time: no new item while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while result pending");

   // result fields stay in their calendar ranges
   a_field_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_second < 6'd60) && (rsp_minute < 6'd60) && (rsp_hour < 5'd24)
                     && (rsp_weekday < 3'd7) && (rsp_month <= LAST_MONTH)
                     && (rsp_month_day != 5'd0)))
      else $error("result field out of range");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before taken");

endmodule

bind epoch_to_calendar_date e2c_checker u_checker (.*);
